>>> src/tr4d_pkg.sv
`timescale 1ns / 1ps
package tr4d_pkg;

   localparam int DIM_W  = 13;
   localparam int IDX_W  = 12;
   localparam int VAL_W  = 32;
   localparam int ROLL_W = 32;
   localparam int AXES   = 4;

   typedef logic [AXES-1:0][DIM_W-1:0]  dim_vec_type;
   typedef logic [AXES-1:0][ROLL_W-1:0] roll_vec_type;

   typedef enum logic [2:0] {
      CSR_DIM_X,
      CSR_DIM_Y,
      CSR_DIM_Z,
      CSR_DIM_W,
      CSR_ROLL_X,
      CSR_ROLL_Y,
      CSR_ROLL_Z,
      CSR_ROLL_W
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD,
      KIND_FETCH
   } kind_type;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // source coordinate: (c + back) wrapped once into 0..n-1
   function automatic logic [IDX_W-1:0] roll_coord(input logic [IDX_W-1:0] c,
                                                   input logic [DIM_W-1:0] back,
                                                   input logic [DIM_W-1:0] n);
      logic [DIM_W:0] s;
      s = (DIM_W+1)'(c) + (DIM_W+1)'(back);
      if (s >= (DIM_W+1)'(n)) begin
         s = s - (DIM_W+1)'(n);
      end
      return s[IDX_W-1:0];
   endfunction

endpackage

>>> src/tr4d_div.sv
`timescale 1ns / 1ps
module tr4d_div #(
   parameter int PAY_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_vld,
   input  logic [tr4d_pkg::IDX_W-1:0]   in_num,
   input  logic [tr4d_pkg::DIM_W-1:0]   divisor,
   input  logic [PAY_W-1:0]             in_pay,
   output logic                         out_vld,
   output logic [tr4d_pkg::IDX_W-1:0]   out_quo,
   output logic [tr4d_pkg::IDX_W-1:0]   out_rem,
   output logic [PAY_W-1:0]             out_pay
);
   import tr4d_pkg::*;

   // one quotient bit per stage, restoring
   logic [IDX_W-1:0]             vld_ff;
   logic [IDX_W-1:0][IDX_W-1:0]  num_ff, num_in;
   logic [IDX_W-1:0][IDX_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0][PAY_W-1:0]  pay_ff;

   always_comb begin
      logic [IDX_W-1:0] num_src;
      logic [IDX_W-1:0] rem_src;
      logic [IDX_W:0]   tmp;
      logic             q;
      for (int k = 0; k < IDX_W; k++) begin
         num_src = (k == 0) ? in_num : num_ff[(k == 0) ? 0 : k-1];
         rem_src = (k == 0) ? '0 : rem_ff[(k == 0) ? 0 : k-1];
         tmp = {rem_src, num_src[IDX_W-1]};
         q = (tmp >= (IDX_W+1)'(divisor));
         if (q) begin
            rem_in[k] = IDX_W'(tmp - (IDX_W+1)'(divisor));
         end else begin
            rem_in[k] = tmp[IDX_W-1:0];
         end
         num_in[k] = {num_src[IDX_W-2:0], q};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[IDX_W-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff    <= num_in;
         rem_ff    <= rem_in;
         pay_ff[0] <= in_pay;
         for (int k = 1; k < IDX_W; k++) begin
            pay_ff[k] <= pay_ff[k-1];
         end
      end
   end

   assign out_vld = vld_ff[IDX_W-1];
   assign out_quo = num_ff[IDX_W-1];
   assign out_rem = rem_ff[IDX_W-1];
   assign out_pay = pay_ff[IDX_W-1];

endmodule

>>> src/tr4d_mod.sv
`timescale 1ns / 1ps
module tr4d_mod (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  tr4d_pkg::dim_vec_type   dims,
   input  tr4d_pkg::roll_vec_type  rolls,
   output logic                    busy,
   output tr4d_pkg::dim_vec_type   back
);
   import tr4d_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN
   } state_type;

   state_type         state_ff;
   logic [1:0]        axis_ff;
   logic [4:0]        step_ff;
   logic [DIM_W-1:0]  rem_ff, rem_in;
   logic [ROLL_W-1:0] mag_ff, mag_start;
   dim_vec_type       back_ff;
   logic [DIM_W-1:0]  n, back_new;
   logic [DIM_W:0]    tmp;
   logic              neg;

   always_comb begin
      n   = dims[axis_ff];
      neg = rolls[axis_ff][ROLL_W-1];
      mag_start = neg ? (~rolls[axis_ff] + 1'b1) : rolls[axis_ff];
      tmp = {rem_ff, mag_ff[ROLL_W-1]};
      if (tmp >= (DIM_W+1)'(n)) begin
         rem_in = DIM_W'(tmp - (DIM_W+1)'(n));
      end else begin
         rem_in = tmp[DIM_W-1:0];
      end
      // back offset: |r| mod n for r < 0, else (n - r mod n) mod n
      if (n == '0) begin
         back_new = '0;
      end else if (neg) begin
         back_new = rem_in;
      end else if (rem_in == '0) begin
         back_new = '0;
      end else begin
         back_new = n - rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= '0;
         step_ff  <= '0;
         back_ff  <= '0;
      end else if (start) begin
         state_ff <= ST_LOAD;
         axis_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
            end
            ST_LOAD: begin
               mag_ff   <= mag_start;
               rem_ff   <= '0;
               step_ff  <= '0;
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               mag_ff  <= {mag_ff[ROLL_W-2:0], 1'b0};
               rem_ff  <= rem_in;
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(ROLL_W-1)) begin
                  back_ff[axis_ff] <= back_new;
                  if (axis_ff == 2'(AXES-1)) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     axis_ff  <= axis_ff + 2'd1;
                     state_ff <= ST_LOAD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign back = back_ff;

endmodule

>>> src/tr4d_store.sv
`timescale 1ns / 1ps
module tr4d_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic                        wr_en,
   input  logic [AW-1:0]               addr,
   input  logic [tr4d_pkg::VAL_W-1:0]  wr_data,
   output logic [tr4d_pkg::VAL_W-1:0]  rd_data
);
   import tr4d_pkg::*;

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/tensor_roll_4d_core.sv
`timescale 1ns / 1ps
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_stall | req_kind, req_elem_index, req_elem_value
// rsp     | out       | rsp_valid / rsp_stall | rsp_out_value, rsp_src_index, rsp_status
// csr     | in        | csr_wr_en             | csr_index, csr_data
//
// One item per cycle while req_stall is low; a fetch is answered once three 12-stage
// pipelined dividers split the index, four stages roll and rebuild it and one stage
// reads the element memory. Loads travel the same pipe and write at the memory stage.
// Any csr write recomputes the four wrapped shifts in a serial modulo unit:
// req_stall stays high while it runs. Synchronous reset clears control only.
// A stalled result freezes the whole pipe.
module tensor_roll_4d_core #(
   parameter int STORE_DEPTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tr4d_pkg::kind_type            req_kind,
   input  logic [tr4d_pkg::IDX_W-1:0]    req_elem_index,
   input  logic [tr4d_pkg::VAL_W-1:0]    req_elem_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tr4d_pkg::VAL_W-1:0]    rsp_out_value,
   output logic [tr4d_pkg::IDX_W-1:0]    rsp_src_index,
   output logic                          rsp_status,
   input  logic                          csr_wr_en,
   input  tr4d_pkg::csr_index_type       csr_index,
   input  logic [tr4d_pkg::ROLL_W-1:0]   csr_data
);
   import tr4d_pkg::*;

   localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int P1W = 1 + IDX_W + VAL_W;
   localparam int P2W = P1W + IDX_W;
   localparam int P3W = P2W + IDX_W;
   localparam int MW  = DIM_W + IDX_W + 1;

   dim_vec_type  dim_ff, back;
   roll_vec_type roll_ff;
   logic         busy, adv, acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            dim_ff[a]  <= DIM_W'(1);
            roll_ff[a] <= '0;
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DIM_X:  dim_ff[0]  <= csr_data[DIM_W-1:0];
            CSR_DIM_Y:  dim_ff[1]  <= csr_data[DIM_W-1:0];
            CSR_DIM_Z:  dim_ff[2]  <= csr_data[DIM_W-1:0];
            CSR_DIM_W:  dim_ff[3]  <= csr_data[DIM_W-1:0];
            CSR_ROLL_X: roll_ff[0] <= csr_data;
            CSR_ROLL_Y: roll_ff[1] <= csr_data;
            CSR_ROLL_Z: roll_ff[2] <= csr_data;
            CSR_ROLL_W: roll_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   tr4d_mod u_mod (
      .clock (clock),
      .reset (reset),
      .start (csr_wr_en),
      .dims  (dim_ff),
      .rolls (roll_ff),
      .busy  (busy),
      .back  (back)
   );

   logic rsp_valid_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = busy || !adv;
   assign acc       = req_valid && !req_stall;

   // index split: x = idx mod nx, then y, z, and w as the last quotient
   logic             d1_vld, d2_vld, d3_vld;
   logic [IDX_W-1:0] d1_quo, d1_rem, d2_quo, d2_rem, d3_quo, d3_rem;
   logic [P1W-1:0]   d1_pay;
   logic [P2W-1:0]   d2_pay;
   logic [P3W-1:0]   d3_pay;

   tr4d_div #(.PAY_W(P1W)) u_div_x (
      .clock (clock), .reset (reset), .en (adv),
      .in_vld (acc), .in_num (req_elem_index), .divisor (dim_ff[0]),
      .in_pay ({req_kind, req_elem_index, req_elem_value}),
      .out_vld (d1_vld), .out_quo (d1_quo), .out_rem (d1_rem), .out_pay (d1_pay)
   );

   tr4d_div #(.PAY_W(P2W)) u_div_y (
      .clock (clock), .reset (reset), .en (adv),
      .in_vld (d1_vld), .in_num (d1_quo), .divisor (dim_ff[1]),
      .in_pay ({d1_pay, d1_rem}),
      .out_vld (d2_vld), .out_quo (d2_quo), .out_rem (d2_rem), .out_pay (d2_pay)
   );

   tr4d_div #(.PAY_W(P3W)) u_div_z (
      .clock (clock), .reset (reset), .en (adv),
      .in_vld (d2_vld), .in_num (d2_quo), .divisor (dim_ff[2]),
      .in_pay ({d2_pay, d2_rem}),
      .out_vld (d3_vld), .out_quo (d3_quo), .out_rem (d3_rem), .out_pay (d3_pay)
   );

   logic             c_kind;
   logic [IDX_W-1:0] c_idx, c_i0, c_i1;
   logic [VAL_W-1:0] c_val;
   logic             c_edim;

   assign {c_kind, c_idx, c_val, c_i0, c_i1} = d3_pay;
   assign c_edim = (dim_ff[0] == '0) || (dim_ff[1] == '0) || (dim_ff[2] == '0)
                || (dim_ff[3] == '0) || ({1'b0, d3_quo} >= dim_ff[3]);

   // roll stage
   logic                        r_vld_ff, r_kind_ff, r_edim_ff;
   logic [IDX_W-1:0]            r_idx_ff;
   logic [VAL_W-1:0]            r_val_ff;
   logic [AXES-1:0][IDX_W-1:0]  r_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
      end else if (adv) begin
         r_vld_ff <= d3_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_kind_ff <= c_kind;
         r_idx_ff  <= c_idx;
         r_val_ff  <= c_val;
         r_edim_ff <= c_edim;
         r_s_ff[0] <= roll_coord(c_i0, back[0], dim_ff[0]);
         r_s_ff[1] <= roll_coord(c_i1, back[1], dim_ff[1]);
         r_s_ff[2] <= roll_coord(d3_rem, back[2], dim_ff[2]);
         r_s_ff[3] <= roll_coord(d3_quo, back[3], dim_ff[3]);
      end
   end

   // rebuild: low 12 bits plus an overflow flag at each Horner step
   logic [MW-1:0] t2_sum, t1_sum, t0_sum;

   logic             p1_vld_ff, p1_kind_ff, p1_edim_ff, p1_ov_ff;
   logic [IDX_W-1:0] p1_idx_ff, p1_s0_ff, p1_s1_ff, p1_t_ff;
   logic [VAL_W-1:0] p1_val_ff;

   assign t2_sum = MW'(r_s_ff[2]) + MW'(dim_ff[2]) * MW'(r_s_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= r_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_kind_ff <= r_kind_ff;
         p1_edim_ff <= r_edim_ff;
         p1_idx_ff  <= r_idx_ff;
         p1_val_ff  <= r_val_ff;
         p1_s0_ff   <= r_s_ff[0];
         p1_s1_ff   <= r_s_ff[1];
         p1_t_ff    <= t2_sum[IDX_W-1:0];
         p1_ov_ff   <= |t2_sum[MW-1:IDX_W];
      end
   end

   logic             p2_vld_ff, p2_kind_ff, p2_edim_ff, p2_ov_ff;
   logic [IDX_W-1:0] p2_idx_ff, p2_s0_ff, p2_t_ff;
   logic [VAL_W-1:0] p2_val_ff;

   assign t1_sum = MW'(p1_s1_ff) + MW'(dim_ff[1]) * MW'(p1_t_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else if (adv) begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_kind_ff <= p1_kind_ff;
         p2_edim_ff <= p1_edim_ff;
         p2_idx_ff  <= p1_idx_ff;
         p2_val_ff  <= p1_val_ff;
         p2_s0_ff   <= p1_s0_ff;
         p2_t_ff    <= t1_sum[IDX_W-1:0];
         p2_ov_ff   <= p1_ov_ff || (|t1_sum[MW-1:IDX_W]);
      end
   end

   // final sum, range checks and memory address
   logic             src_beyond, load_ok;
   logic             m_vld_ff, m_kind_ff, m_wr_ok_ff, m_err_ff;
   logic [IDX_W-1:0] m_addr_ff, m_src_ff;
   logic [VAL_W-1:0] m_val_ff;

   assign t0_sum = MW'(p2_s0_ff) + MW'(dim_ff[0]) * MW'(p2_t_ff);
   assign src_beyond = p2_ov_ff || (|t0_sum[MW-1:IDX_W])
                    || (32'(t0_sum[IDX_W-1:0]) >= 32'(STORE_DEPTH));
   assign load_ok = 32'(p2_idx_ff) < 32'(STORE_DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_kind_ff  <= p2_kind_ff;
         m_val_ff   <= p2_val_ff;
         m_wr_ok_ff <= load_ok;
         m_err_ff   <= p2_edim_ff || src_beyond;
         m_src_ff   <= p2_edim_ff ? '0 : t0_sum[IDX_W-1:0];
         m_addr_ff  <= (p2_kind_ff == KIND_LOAD) ? p2_idx_ff : t0_sum[IDX_W-1:0];
      end
   end

   logic             mem_rd, mem_wr;
   logic [VAL_W-1:0] mem_q;

   assign mem_wr = adv && m_vld_ff && (m_kind_ff == KIND_LOAD) && m_wr_ok_ff;
   assign mem_rd = adv && m_vld_ff && (m_kind_ff == KIND_FETCH) && !m_err_ff;

   tr4d_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
      .clock   (clock),
      .rd_en   (mem_rd),
      .wr_en   (mem_wr),
      .addr    (AW'(m_addr_ff)),
      .wr_data (m_val_ff),
      .rd_data (mem_q)
   );

   logic             rsp_status_ff;
   logic [IDX_W-1:0] rsp_src_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= m_vld_ff && (m_kind_ff == KIND_FETCH);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_src_ff    <= m_src_ff;
         rsp_status_ff <= m_err_ff ? STATUS_ERR : STATUS_OK;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_src_index = rsp_src_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = (rsp_status_ff == STATUS_ERR) ? '0 : mem_q;

endmodule

>>> src/tr4d_check.sv
`timescale 1ns / 1ps
module tr4d_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [tr4d_pkg::VAL_W-1:0]    rsp_out_value,
   input logic [tr4d_pkg::IDX_W-1:0]    rsp_src_index,
   input logic                          rsp_status,
   input logic                          csr_wr_en
);
   import tr4d_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_value)
         && $stable(rsp_src_index) && $stable(rsp_status))
      else $error("stalled result changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_ERR) |-> rsp_out_value == '0)
      else $error("error result carries nonzero value");

   a_csr_stall: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> req_stall)
      else $error("input taken while shifts recompute");

endmodule

bind tensor_roll_4d_core tr4d_check u_check (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_value (rsp_out_value),
   .rsp_src_index (rsp_src_index),
   .rsp_status    (rsp_status),
   .csr_wr_en     (csr_wr_en)
);

>>> tb/sv/tensor_roll_4d_core_tb.sv
`timescale 1ns / 1ps
module tensor_roll_4d_core_tb;
   import tr4d_pkg::*;

   localparam int DEPTH      = 4096;
   localparam int DRAIN_WAIT = 60;
   localparam int WD_LIMIT   = 3000;

   typedef struct {
      kind_type          kind;
      logic [IDX_W-1:0]  index;
      logic [VAL_W-1:0]  value;
   } elem_item_type;

   typedef struct {
      logic [VAL_W-1:0]  value;
      logic [IDX_W-1:0]  src;
      logic              status;
   } roll_result_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   kind_type             req_kind;
   logic [IDX_W-1:0]     req_elem_index;
   logic [VAL_W-1:0]     req_elem_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [VAL_W-1:0]     rsp_out_value;
   logic [IDX_W-1:0]     rsp_src_index;
   logic                 rsp_status;
   logic                 csr_wr_en;
   csr_index_type        csr_index;
   logic [ROLL_W-1:0]    csr_data;

   elem_item_type        pending_items[$];
   roll_result_type      expected_rolls[$];
   logic [VAL_W-1:0]     elem_mirror[DEPTH];
   bit                   queued_written[DEPTH];
   longint               cur_dim[AXES];
   longint               cur_roll[AXES];
   int                   errors;
   int                   cycle_count;
   int                   quiet_cycles;
   bit                   req_taken;
   bit                   long_hold_req;
   int                   hold_left;

   tensor_roll_4d_core #(.STORE_DEPTH(DEPTH)) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // source of dst; ok is false on a zero extent or dst past the tensor
   function automatic void rolled_source(input logic [IDX_W-1:0] dst, output longint src,
                                         output bit ok);
      longint count, rest, c, r, back, s, mul;
      src = 0;
      ok = 0;
      count = 1;
      for (int a = 0; a < AXES; a++) begin
         if (cur_dim[a] == 0) return;
         count = count * cur_dim[a];
      end
      if (longint'(dst) >= count) return;
      rest = longint'(dst);
      mul = 1;
      for (int a = 0; a < AXES; a++) begin
         c = rest % cur_dim[a];
         rest = rest / cur_dim[a];
         r = cur_roll[a] % cur_dim[a];
         if (r < 0) r = r + cur_dim[a];
         back = (cur_dim[a] - r) % cur_dim[a];
         s = c + back;
         if (s >= cur_dim[a]) s = s - cur_dim[a];
         src = src + s * mul;
         mul = mul * cur_dim[a];
      end
      ok = 1;
   endfunction

   function automatic roll_result_type predict_fetch(input logic [IDX_W-1:0] dst);
      roll_result_type res;
      longint src;
      bit ok;
      rolled_source(dst, src, ok);
      res.value = '0;
      res.src = ok ? src[IDX_W-1:0] : '0;
      res.status = STATUS_ERR;
      if (ok && src < DEPTH) begin
         res.value = elem_mirror[src];
         res.status = STATUS_OK;
      end
      return res;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
               cycle_count);
      errors++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [ROLL_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      if (idx <= CSR_DIM_W) cur_dim[idx] = longint'(data[DIM_W-1:0]);
      else cur_roll[idx - CSR_ROLL_X] = longint'($signed(data));
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_shape(input int dx, dy, dz, dw, input logic [31:0] rx, ry, rz, rw);
      write_csr(CSR_DIM_X, dx);
      write_csr(CSR_DIM_Y, dy);
      write_csr(CSR_DIM_Z, dz);
      write_csr(CSR_DIM_W, dw);
      write_csr(CSR_ROLL_X, rx);
      write_csr(CSR_ROLL_Y, ry);
      write_csr(CSR_ROLL_Z, rz);
      write_csr(CSR_ROLL_W, rw);
   endtask

   task automatic push_load(input int idx, input logic [VAL_W-1:0] val);
      elem_item_type it;
      it.kind = KIND_LOAD;
      it.index = IDX_W'(idx);
      it.value = val;
      queued_written[idx] = 1;
      pending_items.push_back(it);
   endtask

   // fetch only entries that are written by the time it arrives
   task automatic push_fetch(input int idx);
      elem_item_type it;
      longint src;
      bit ok;
      rolled_source(IDX_W'(idx), src, ok);
      if (ok && src < DEPTH && !queued_written[src]) push_load(int'(src), $urandom);
      it.kind = KIND_FETCH;
      it.index = IDX_W'(idx);
      it.value = $urandom;
      pending_items.push_back(it);
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_rolls.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic random_items(input int n);
      longint count;
      int span;
      count = 1;
      for (int a = 0; a < AXES; a++) count = count * cur_dim[a];
      span = (count == 0) ? DEPTH : ((count > DEPTH) ? DEPTH : int'(count));
      for (int i = 0; i < n; i++) begin
         int idx;
         idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, DEPTH - 1)
                                           : $urandom_range(0, span - 1);
         if ($urandom_range(0, 9) < 4) push_load(idx, $urandom);
         else push_fetch(idx);
      end
   endtask

   // stimulus
   initial begin
      errors = 0;
      long_hold_req = 0;
      csr_wr_en = 1'b0;
      csr_index = CSR_DIM_X;
      csr_data = '0;
      for (int a = 0; a < AXES; a++) begin
         cur_dim[a] = 1;
         cur_roll[a] = 0;
      end
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset shape: single element
      push_load(0, 32'hFFFF_FFFF);
      push_fetch(0);
      push_fetch(4095);
      push_load(0, 32'h0);
      push_fetch(0);
      push_load(4095, 32'h8000_0001);
      wait_idle();

      // full flat axis, zero shifts
      set_shape(4096, 1, 1, 1, 0, 0, 0, 0);
      push_fetch(4095);
      push_fetch(0);
      push_fetch(1234);
      wait_idle();
      // empty tensor
      set_shape(4, 0, 2, 2, 1, 1, 1, 1);
      push_fetch(0);
      push_fetch(3);
      wait_idle();
      // extreme shifts on a full tensor
      set_shape(16, 16, 4, 4, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
      push_fetch(0);
      push_fetch(4095);
      push_fetch(2049);
      wait_idle();
      // extents larger than the store: sources may land past it
      set_shape(4096, 4096, 4096, 4096, 32'h0000_0005, 32'h8000_0000, 32'h0, 32'hFFFF_FFF0);
      push_fetch(0);
      push_fetch(4095);
      push_fetch(17);
      wait_idle();

      for (int ph = 0; ph < 22; ph++) begin
         int dmax;
         dmax = (ph % 5 == 4) ? 16 : 8;
         set_shape($urandom_range(ph == 7 ? 0 : 1, dmax), $urandom_range(1, dmax),
                   $urandom_range(1, dmax), $urandom_range(1, (ph % 6 == 5) ? 64 : 4),
                   (ph % 4 == 0) ? $urandom_range(0, 20) - 10 : $urandom,
                   (ph % 4 == 1) ? 32'h0 : $urandom,
                   $urandom_range(0, 6) - 3, $urandom);
         if (ph == 10) long_hold_req = 1;
         random_items(55);
         wait_idle();
      end

      if (errors == 0) $display("tensor_roll_4d_core test passed");
      else $display("tensor_roll_4d_core test failed");
      $finish;
   end

   // driver
   always @(negedge clock) begin
      elem_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         req_kind <= KIND_LOAD;
         req_elem_index <= '0;
         req_elem_value <= '0;
      end else if (!req_valid || req_taken) begin
         if (pending_items.size() != 0 && (quiet_cycles > 0 || $urandom_range(0, 99) >= 12))
         begin
            it = pending_items.pop_front();
            req_valid <= 1'b1;
            req_kind <= it.kind;
            req_elem_index <= it.index;
            req_elem_value <= it.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (long_hold_req) begin
            long_hold_req = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (quiet_cycles == 0) && ($urandom_range(0, 99) < 12);
         end
      end
   end

   // accept, predict and check
   always @(posedge clock) begin
      roll_result_type want;
      if (reset) begin
         cycle_count <= 0;
         quiet_cycles <= 0;
         req_taken = 0;
      end else begin
         cycle_count <= cycle_count + 1;
         // one long stretch without idling on either side
         if (cycle_count == 4000) quiet_cycles <= 3000;
         else if (quiet_cycles > 0) quiet_cycles <= quiet_cycles - 1;
         req_taken = req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            if (req_kind == KIND_LOAD) elem_mirror[req_elem_index] = req_elem_value;
            else expected_rolls.push_back(predict_fetch(req_elem_index));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rolls.size() == 0) begin
               report("unexpected result", rsp_src_index, 0);
            end else begin
               want = expected_rolls.pop_front();
               if (rsp_out_value !== want.value) report("out_value", rsp_out_value, want.value);
               if (rsp_src_index !== want.src) report("src_index", rsp_src_index, want.src);
               if (rsp_status !== want.status) report("status", rsp_status, want.status);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      int idle_run;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_run = 0;
      end else begin
         idle_run++;
         if (idle_run >= WD_LIMIT) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("tensor_roll_4d_core test failed");
            $finish;
         end
      end
   end

endmodule
